>>> sv/u8san_pkg.sv
// Shared types, constants and byte classification for the UTF-8 sanitiser.
// Used by every module of the block; depends on nothing.
package u8san_pkg;

    localparam logic [7:0] UNDERSCORE = 8'h5F;
    localparam int MAX_RES = 4;
    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);

    typedef logic [7:0] t_byte;

    typedef struct packed {
        t_byte [MAX_RES-1:0] bytes;
        logic [MAX_RES-1:0]  repl;
        logic [2:0]          count;
    } t_job;

    typedef struct packed {
        logic       ok;
        logic [1:0] extra;
    } t_lead;

    function automatic t_lead classify(input t_byte b);
        t_lead l;
        l = '0;
        priority if ((b & 8'h80) == 8'h00) begin
            l.ok = 1'b1;
            l.extra = 2'd0;
        end else if ((b & 8'hE0) == 8'hC0) begin
            l.ok = 1'b1;
            l.extra = 2'd1;
        end else if ((b & 8'hF0) == 8'hE0) begin
            l.ok = 1'b1;
            l.extra = 2'd2;
        end else if ((b & 8'hF8) == 8'hF0) begin
            l.ok = 1'b1;
            l.extra = 2'd3;
        end else begin
            l.ok = 1'b0;
            l.extra = 2'd0;
        end
        return l;
    endfunction

    function automatic logic is_cont(input t_byte b);
        return (b & 8'hC0) == 8'h80;
    endfunction

endpackage

>>> sv/u8san_in_if.sv
// Input channel of the UTF-8 sanitiser: valid/ready handshake with one raw byte per beat.
// Depends on nothing.
interface u8san_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink (input valid, input in_byte, input end_of_string, output ready);
endinterface

>>> sv/u8san_out_if.sv
// Output channel of the UTF-8 sanitiser: valid/ready handshake with one result byte per beat.
// Depends on nothing.
interface u8san_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       was_replaced;
    logic       run_end;

    modport source (output valid, output out_byte, output was_replaced, output run_end,
                    input ready);
    modport sink (input valid, input out_byte, input was_replaced, input run_end,
                  output ready);
endinterface

>>> sv/u8san_front.sv
// Front end: accepts input beats, tracks the pending sequence and builds one job of
// up to four result bytes per beat. Depends on u8san_pkg and u8san_in_if.
module u8san_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    u8san_in_if.sink          i_in,
    input  logic              i_full,
    output logic              o_push,
    output u8san_pkg::t_job   o_job
);

    logic [1:0]       r_cnt;
    logic [1:0]       n_cnt;
    logic [1:0]       r_exp;
    logic [1:0]       n_exp;
    u8san_pkg::t_byte r_pb [3];
    logic             pb_we;
    logic [1:0]       pb_idx;
    logic             acc;
    logic             cont;
    logic             complete;
    u8san_pkg::t_lead lead;
    u8san_pkg::t_byte b;
    logic             eos;

    assign i_in.ready = !i_full;
    assign acc = i_in.valid && !i_full;
    assign b = i_in.in_byte;
    assign eos = i_in.end_of_string;
    assign lead = u8san_pkg::classify(b);
    assign cont = u8san_pkg::is_cont(b);
    assign complete = (r_cnt >= r_exp);

    always_comb begin
        o_job.bytes = {u8san_pkg::MAX_RES{u8san_pkg::UNDERSCORE}};
        o_job.repl = '1;
        o_job.count = 3'd0;
        n_cnt = r_cnt;
        n_exp = r_exp;
        pb_we = 1'b0;
        pb_idx = r_cnt;
        priority if (r_cnt != 2'd0 && cont && complete) begin
            for (int i = 0; i < 3; i++) begin
                if (2'(i) < r_cnt) begin
                    o_job.bytes[i] = r_pb[i];
                    o_job.repl[i] = 1'b0;
                end
            end
            o_job.bytes[r_cnt] = b;
            o_job.repl[r_cnt] = 1'b0;
            o_job.count = {1'b0, r_cnt} + 3'd1;
            n_cnt = 2'd0;
            n_exp = 2'd0;
        end else if (r_cnt != 2'd0 && cont) begin
            pb_we = 1'b1;
            if (eos) begin
                o_job.count = {1'b0, r_cnt} + 3'd1;
                n_cnt = 2'd0;
                n_exp = 2'd0;
            end else begin
                n_cnt = r_cnt + 2'd1;
            end
        end else begin
            if (lead.ok && lead.extra != 2'd0) begin
                pb_we = 1'b1;
                pb_idx = 2'd0;
                o_job.count = {1'b0, r_cnt} + {2'b00, eos};
                n_cnt = eos ? 2'd0 : 2'd1;
                n_exp = eos ? 2'd0 : lead.extra;
            end else begin
                if (lead.ok) begin
                    o_job.bytes[r_cnt] = b;
                    o_job.repl[r_cnt] = 1'b0;
                end
                o_job.count = {1'b0, r_cnt} + 3'd1;
                n_cnt = 2'd0;
                n_exp = 2'd0;
            end
        end
    end

    assign o_push = acc && (o_job.count != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
            r_exp <= 2'd0;
        end else if (acc) begin
            r_cnt <= n_cnt;
            r_exp <= n_exp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && pb_we) begin
            r_pb[pb_idx] <= b;
        end
    end

endmodule

>>> sv/u8san_queue.sv
// Short job queue that decouples the front end from the output stage.
// Depends on u8san_pkg.
module u8san_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u8san_pkg::t_job i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output u8san_pkg::t_job o_head
);

    u8san_pkg::t_job             r_mem [u8san_pkg::QDEPTH];
    logic [u8san_pkg::QAW-1:0]   r_wp;
    logic [u8san_pkg::QAW-1:0]   r_rp;
    logic [u8san_pkg::QAW:0]     r_fill;

    assign o_full = (r_fill == (u8san_pkg::QAW+1)'(u8san_pkg::QDEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + (u8san_pkg::QAW)'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + (u8san_pkg::QAW)'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + (u8san_pkg::QAW+1)'(1);
                2'b01:   r_fill <= r_fill - (u8san_pkg::QAW+1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

>>> sv/u8san_back.sv
// Output stage: unpacks the head job of the queue into one result beat per cycle
// unless stalled, via an output register. Depends on u8san_pkg and u8san_out_if.
module u8san_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  u8san_pkg::t_job i_head,
    output logic            o_pop,
    u8san_out_if.source     o_out
);

    logic             r_valid;
    u8san_pkg::t_byte r_byte;
    logic             r_repl;
    logic             r_end;
    logic [1:0]       r_idx;
    logic             load;
    logic             last;

    assign load = !i_empty && (!r_valid || o_out.ready);
    assign last = ({1'b0, r_idx} == (i_head.count - 3'd1));
    assign o_pop = load && last;

    assign o_out.valid = r_valid;
    assign o_out.out_byte = r_byte;
    assign o_out.was_replaced = r_repl;
    assign o_out.run_end = r_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx <= 2'd0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx <= last ? 2'd0 : r_idx + 2'd1;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_head.bytes[r_idx];
            r_repl <= i_head.repl[r_idx];
            r_end <= last;
        end
    end

endmodule

>>> sv/utf8_sanitizer_top.sv
// UTF-8 sanitiser top level: takes one byte per beat and returns the cleaned byte
// stream. Well-formed sequences of one to four bytes are passed on unchanged once
// complete; a broken sequence or an invalid lead byte comes out as underscores with
// was_replaced set, and end_of_string flushes any held bytes in the same way. Each
// input beat yields zero to four result beats, the last one marked by run_end. The
// front end accepts a byte every cycle while its four-entry job queue has room; the
// output register delivers one result per cycle, so a stream sustains one byte per
// cycle, and only a receiver that holds off or a run of beats that each release
// several results stalls the input once the queue fills. A beat's job is written
// into the queue, and its results then leave through the output register. Depends
// on u8san_pkg, u8san_in_if, u8san_out_if and the three submodules.
module utf8_sanitizer_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    u8san_in_if.sink     i_in,
    u8san_out_if.source  o_out
);

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    u8san_pkg::t_job job;
    u8san_pkg::t_job head;

    u8san_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push),
        .o_job   (job)
    );

    u8san_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    u8san_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

>>> sim/utf8_sanitizer_top_tb.sv
// Testbench for utf8_sanitizer_top: drives byte beats and predicts the cleaned stream.
// Checks every result beat in order against its own sanitiser model.
// Depends on u8san_pkg, u8san_in_if, u8san_out_if and utf8_sanitizer_top.
module utf8_sanitizer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef u8san_pkg::t_byte t_byte;

    localparam t_byte REPL_CHAR = 8'h5F;
    localparam int RANDOM_ITEMS = 250;
    localparam int HOLD_LEN = 60;
    localparam int CYCLE_LIMIT = 200000;

    typedef enum logic [2:0] {
        LEAD_ASCII,
        LEAD_TWO,
        LEAD_THREE,
        LEAD_FOUR,
        LEAD_INVALID
    } t_lead_kind;

    typedef struct packed {
        t_byte out_byte;
        logic  was_replaced;
        logic  run_end;
    } t_clean;

    logic clk;
    logic rst_n;

    u8san_in_if  in_if ();
    u8san_out_if out_if ();

    utf8_sanitizer_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_byte      held_q [3];
    logic [1:0] held_n;
    logic [1:0] want_n;
    t_clean     step_q [$];
    t_clean     cleaned_q [$];

    int  fail_cnt = 0;
    int  cycle_cnt = 0;
    bit  sender_idle = 1'b1;
    bit  sink_idle = 1'b1;
    bit  hold_req = 1'b0;
    int  hold_left = 0;
    int  stall_left = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic t_lead_kind lead_kind(input t_byte b);
        if (b[7] == 1'b0) return LEAD_ASCII;
        if (b[7:5] == 3'b110) return LEAD_TWO;
        if (b[7:4] == 4'b1110) return LEAD_THREE;
        if (b[7:3] == 5'b11110) return LEAD_FOUR;
        return LEAD_INVALID;
    endfunction

    function automatic void emit(input t_byte b, input logic repl);
        step_q.push_back('{b, repl, 1'b0});
    endfunction

    function automatic void flush_held();
        repeat (held_n) emit(REPL_CHAR, 1'b1);
        held_n = 2'd0;
        want_n = 2'd0;
    endfunction

    function automatic void open_sequence(input t_byte b);
        case (lead_kind(b))
            LEAD_ASCII: begin
                emit(b, 1'b0);
            end
            LEAD_TWO: begin
                held_q[0] = b;
                held_n = 2'd1;
                want_n = 2'd1;
            end
            LEAD_THREE: begin
                held_q[0] = b;
                held_n = 2'd1;
                want_n = 2'd2;
            end
            LEAD_FOUR: begin
                held_q[0] = b;
                held_n = 2'd1;
                want_n = 2'd3;
            end
            default: begin
                emit(REPL_CHAR, 1'b1);
            end
        endcase
    endfunction

    // Works out the result beats that one accepted input beat releases.
    function automatic void sanitise_byte(input t_byte b, input logic eos);
        int i;
        step_q.delete();
        if (held_n == 2'd0) begin
            open_sequence(b);
        end else if (b[7:6] == 2'b10) begin
            if (held_n >= want_n) begin
                for (i = 0; i < held_n; i++) emit(held_q[i], 1'b0);
                emit(b, 1'b0);
                held_n = 2'd0;
                want_n = 2'd0;
            end else begin
                held_q[held_n] = b;
                held_n = held_n + 2'd1;
            end
        end else begin
            flush_held();
            open_sequence(b);
        end
        if (eos) flush_held();
        if (step_q.size() > 0) step_q[step_q.size() - 1].run_end = 1'b1;
        for (i = 0; i < step_q.size(); i++) cleaned_q.push_back(step_q[i]);
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(15, 30);
    endfunction

    always @(posedge clk) begin
        t_clean want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (cleaned_q.size() == 0) begin
                $error("result beat with nothing expected: out_byte %h", out_if.out_byte);
                fail_cnt++;
            end else begin
                want = cleaned_q.pop_front();
                if (out_if.out_byte !== want.out_byte) begin
                    $error("out_byte: expected %h, got %h", want.out_byte, out_if.out_byte);
                    fail_cnt++;
                end
                if (out_if.was_replaced !== want.was_replaced) begin
                    $error("was_replaced: expected %b, got %b",
                           want.was_replaced, out_if.was_replaced);
                    fail_cnt++;
                end
                if (out_if.run_end !== want.run_end) begin
                    $error("run_end: expected %b, got %b", want.run_end, out_if.run_end);
                    fail_cnt++;
                end
            end
        end
    end

    // The receiver counts out a long hold when asked, else it stalls at random if sink_idle.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_left = HOLD_LEN;
                hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                out_if.ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_if.ready = 1'b0;
                stall_left--;
            end else begin
                out_if.ready = rst_n;
                if (sink_idle) stall_left = pick_gap();
            end
        end
    end

    task automatic send_byte(input t_byte b, input logic eos);
        int gap;
        in_if.valid = 1'b1;
        in_if.in_byte = b;
        in_if.end_of_string = eos;
        do @(posedge clk); while (!in_if.ready);
        sanitise_byte(b, eos);
        @(negedge clk);
        gap = sender_idle ? pick_gap() : 0;
        if (gap > 0) begin
            in_if.valid = 1'b0;
            in_if.in_byte = t_byte'($urandom_range(0, 255));
            in_if.end_of_string = 1'($urandom_range(0, 1));
            repeat (gap) @(negedge clk);
        end
    endtask

    function automatic t_byte rand_lead(input int extra);
        case (extra)
            0: return t_byte'($urandom_range(0, 127));
            1: return 8'hC0 | t_byte'($urandom_range(0, 31));
            2: return 8'hE0 | t_byte'($urandom_range(0, 15));
            default: return 8'hF0 | t_byte'($urandom_range(0, 7));
        endcase
    endfunction

    function automatic t_byte rand_cont();
        return 8'h80 | t_byte'($urandom_range(0, 63));
    endfunction

    function automatic t_byte rand_bad_lead();
        if ($urandom_range(0, 1) != 0) return rand_cont();
        return 8'hF8 | t_byte'($urandom_range(0, 7));
    endfunction

    function automatic logic rand_eos();
        return $urandom_range(0, 15) == 0;
    endfunction

    task automatic test_ascii();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
    endtask

    task automatic test_whole_sequences();
        send_byte(8'hDF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
    endtask

    task automatic test_invalid_leads();
        send_byte(8'h80, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hF8, 1'b0);
    endtask

    task automatic test_broken_sequences();
        send_byte(8'hC3, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    task automatic test_end_of_string();
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b1);
        send_byte(8'hC3, 1'b1);
        send_byte(8'h41, 1'b1);
    endtask

    // Each block ends in a byte that releases four beats, so the queue fills during the hold.
    task automatic test_output_hold();
        int i;
        sender_idle = 1'b0;
        hold_req = 1'b1;
        for (i = 0; i < 8; i++) begin
            send_byte(8'hF0, 1'b0);
            send_byte(8'h90, 1'b0);
            send_byte(8'h80, 1'b0);
            send_byte(8'h41, 1'b0);
        end
        sender_idle = 1'b1;
    endtask

    task automatic test_random_stream();
        int sent;
        int next_shuffle;
        int kind;
        int extra;
        int k;
        int n_cont;
        t_byte b;
        sent = 0;
        next_shuffle = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent >= next_shuffle) begin
                sender_idle = $urandom_range(0, 3) != 0;
                sink_idle = $urandom_range(0, 3) != 0;
                next_shuffle = sent + 30;
            end
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                extra = $urandom_range(0, 3);
                send_byte(rand_lead(extra), rand_eos());
                for (k = 0; k < extra; k++) send_byte(rand_cont(), rand_eos());
                sent += extra + 1;
            end else if (kind < 75) begin
                extra = $urandom_range(1, 3);
                n_cont = $urandom_range(0, extra - 1);
                send_byte(rand_lead(extra), rand_eos());
                for (k = 0; k < n_cont; k++) send_byte(rand_cont(), rand_eos());
                b = t_byte'($urandom_range(0, 255));
                if (b[7:6] == 2'b10) b = b | 8'h40;
                send_byte(b, rand_eos());
                sent += n_cont + 2;
            end else if (kind < 85) begin
                send_byte(rand_bad_lead(), rand_eos());
                sent++;
            end else begin
                send_byte(t_byte'($urandom_range(0, 255)), rand_eos());
                sent++;
            end
        end
        sender_idle = 1'b1;
        sink_idle = 1'b1;
    endtask

    initial begin
        rst_n = 1'b0;
        in_if.valid = 1'b0;
        in_if.in_byte = '0;
        in_if.end_of_string = 1'b0;
        held_n = 2'd0;
        want_n = 2'd0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_ascii();
        test_whole_sequences();
        test_invalid_leads();
        test_broken_sequences();
        test_end_of_string();
        test_output_hold();
        test_random_stream();

        in_if.valid = 1'b0;
        while (cleaned_q.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_cnt == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/u8san_pkg.sv
sv/u8san_in_if.sv
sv/u8san_out_if.sv
sv/u8san_front.sv
sv/u8san_queue.sv
sv/u8san_back.sv
sv/utf8_sanitizer_top.sv
sim/utf8_sanitizer_top_tb.sv
